/* hdl/chroma_dc_ac_prediction_neighbors_assert.svh */
// Assertion helpers for the chroma prediction neighbor block.
`ifndef CHROMA_DC_AC_PREDICTION_NEIGHBORS_ASSERT_SVH
`define CHROMA_DC_AC_PREDICTION_NEIGHBORS_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define CDAP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CDAP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/cdap_pkg.sv */
package cdap_pkg;

    localparam int VEC_LEN    = 16;
    localparam int COEF_IDX_W = 4;
    localparam int POS_W      = 16;
    localparam int COEF_W     = 16;
    localparam int MBS_W      = 7;
    localparam int PIX_W      = 4;
    localparam int SINCE_W    = 7;

    // Divisor covers the full column range of the block (9 bits, values up to 511).
    localparam int DVS_W      = 9;
    localparam int ITER_W     = 4;
    localparam logic [ITER_W-1:0] ITER_LAST = 4'd15;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] REG_MBS_PER_ROW = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BITS  = 1'd1;

    localparam logic [MBS_W-1:0] MBS_RESET = 7'd22;
    localparam logic [PIX_W-1:0] PIX_RESET = 4'd8;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_PLAN,
        S_RD_B,
        S_RD_C,
        S_WR,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        K_CLEAR,
        K_FIRST_ROW,
        K_FIRST_COL,
        K_GENERAL
    } t_kind;

    typedef struct packed {
        logic             start;
        logic [POS_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_rem_req;

    typedef struct packed {
        logic             done;
        logic [DVS_W-1:0] remainder;
    } t_rem_rsp;

endpackage

/* hdl/cdap_in_if.sv */
interface cdap_in_if;
    logic                                    valid;
    logic                                    ready;
    logic        [cdap_pkg::POS_W-1:0]       mb_position;
    logic                                    resync;
    logic        [cdap_pkg::COEF_IDX_W-1:0]  coef_index;
    logic signed [cdap_pkg::COEF_W-1:0]      left_coef;

    modport source (output valid, output mb_position, output resync,
                    output coef_index, output left_coef, input ready);
    modport sink   (input valid, input mb_position, input resync,
                    input coef_index, input left_coef, output ready);
endinterface

/* hdl/cdap_out_if.sv */
interface cdap_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [cdap_pkg::COEF_W-1:0] pred_left;
    logic signed [cdap_pkg::COEF_W-1:0] pred_above_left;
    logic signed [cdap_pkg::COEF_W-1:0] pred_above;

    modport source (output valid, output pred_left, output pred_above_left,
                    output pred_above, input ready);
    modport sink   (input valid, input pred_left, input pred_above_left,
                    input pred_above, output ready);
endinterface

/* hdl/cdap_rem.sv */
// Restoring remainder unit: one quotient bit per cycle.
module cdap_rem (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cdap_pkg::t_rem_req i_req,
    output cdap_pkg::t_rem_rsp o_rsp
);

    logic                              r_busy;
    logic                              r_done;
    logic [cdap_pkg::ITER_W-1:0]       r_cnt;
    logic [cdap_pkg::POS_W-1:0]        r_dvd;
    logic [cdap_pkg::DVS_W-1:0]        r_dvs;
    logic [cdap_pkg::DVS_W-1:0]        r_rem;
    logic [cdap_pkg::DVS_W-1:0]        w_trial;
    logic [cdap_pkg::DVS_W-1:0]        n_rem;

    // Remainder stays below the divisor, so its top bit is free for the shift.
    assign w_trial = {r_rem[cdap_pkg::DVS_W-2:0], r_dvd[cdap_pkg::POS_W-1]};
    assign n_rem   = (w_trial >= r_dvs) ? (w_trial - r_dvs) : w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == cdap_pkg::ITER_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[cdap_pkg::POS_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.remainder = r_rem;

endmodule

/* hdl/chroma_dc_ac_prediction_neighbors.sv */
// Channel   Dir  Payload                                        Handshake
// i_in      in   mb_position, resync, coef_index, left_coef     valid/ready
// o_out     out  pred_left, pred_above_left, pred_above         valid/ready
// i_cfg_*   in   register index, write data                     write enable only
//
// One beat at a time: ready is high only while the sequencer idles.
// Position found in the column cache: plan, read above-left (general), read above (general and first
// column), write, output, set by the line store's one read port, used up to twice, and one write.
// New position: the bit-serial position-mod-columns unit runs first.
// Picture start or resync: straight to output, then a MAX_COLS*16 entry clearing pass (1024 at the
// default), which reset also starts with. A stalled output holds its beat; the next is taken.
module chroma_dc_ac_prediction_neighbors #(
    parameter int MAX_COLS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cdap_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cdap_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    cdap_in_if.sink                             i_in,
    cdap_out_if.source                          o_out
);

    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CNT_W = $clog2(MAX_COLS + 1);
    localparam int AW    = CW + cdap_pkg::COEF_IDX_W;
    localparam int DEPTH = MAX_COLS * cdap_pkg::VEC_LEN;
    localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);

    // Configuration registers.
    logic [cdap_pkg::MBS_W-1:0]   r_mbs;
    logic [cdap_pkg::PIX_W-1:0]   r_pix;

    // Sequencer and latched beat.
    cdap_pkg::t_state             r_state;
    cdap_pkg::t_state             n_state;
    cdap_pkg::t_kind              r_kind;
    cdap_pkg::t_kind              w_kind;
    logic [cdap_pkg::POS_W-1:0]   r_pos;
    logic                         r_rs;
    logic [cdap_pkg::COEF_IDX_W-1:0] r_k;
    logic [cdap_pkg::COEF_W-1:0]  r_x;
    logic [cdap_pkg::SINCE_W-1:0] r_since;
    logic [cdap_pkg::SINCE_W-1:0] w_since_base;
    logic [AW-1:0]                r_clr_addr;

    // Column cache: last position and its column / first-row flag.
    logic                         r_c_ok;
    logic [cdap_pkg::POS_W-1:0]   r_c_pos;
    logic [CW-1:0]                r_c_col;
    logic                         r_c_row0;

    // Line store.
    logic [cdap_pkg::COEF_W-1:0]  mem [DEPTH];
    logic [cdap_pkg::COEF_W-1:0]  r_rdata;
    logic [cdap_pkg::COEF_W-1:0]  r_b;
    logic [cdap_pkg::COEF_W-1:0]  r_c;
    logic                         w_we;
    logic [AW-1:0]                w_waddr;
    logic [AW-1:0]                w_raddr;
    logic [cdap_pkg::COEF_W-1:0]  w_wdata;

    // Output register.
    logic                         r_out_valid;
    logic [cdap_pkg::COEF_W-1:0]  r_out_a;
    logic [cdap_pkg::COEF_W-1:0]  r_out_b;
    logic [cdap_pkg::COEF_W-1:0]  r_out_c;
    logic [cdap_pkg::COEF_W-1:0]  w_res_a;
    logic [cdap_pkg::COEF_W-1:0]  w_res_b;
    logic [cdap_pkg::COEF_W-1:0]  w_res_c;
    logic                         w_out_load;

    logic                         w_accept;
    logic                         w_clear_ev;
    logic                         w_hit;
    logic [CNT_W-1:0]             w_eff;
    logic [CW-1:0]                w_col_m1;
    logic [CW-1:0]                w_last_col;
    logic [cdap_pkg::COEF_W-1:0]  w_dflt;
    logic [cdap_pkg::COEF_W-1:0]  w_miss;
    logic                         w_since_lt;

    cdap_pkg::t_rem_req           w_rem_req;
    cdap_pkg::t_rem_rsp           w_rem_rsp;

    cdap_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_rem_req),
        .o_rsp   (w_rem_rsp)
    );

    // Clamp the column count to 1..MAX_COLS.
    always_comb begin
        if (r_mbs == '0) begin
            w_eff = CNT_W'(1);
        end else if (32'(r_mbs) > MAX_COLS) begin
            w_eff = CNT_W'(MAX_COLS);
        end else begin
            w_eff = CNT_W'(r_mbs);
        end
    end

    // DC default wraps to 16 bits for large pixel widths.
    assign w_dflt = 16'd1 << (5'(r_pix) + 5'd2);
    assign w_miss = (r_k == '0) ? w_dflt : '0;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_clear_ev = (i_in.mb_position == '0) || i_in.resync;
    assign w_hit      = r_c_ok && (i_in.mb_position == r_c_pos);
    assign w_col_m1   = r_c_col - CW'(1);
    assign w_last_col = CW'(w_eff - CNT_W'(1));
    assign w_since_lt = 32'(r_since) < 32'(w_eff);

    always_comb begin
        if (r_c_row0 || w_since_lt) begin
            w_kind = cdap_pkg::K_FIRST_ROW;
        end else if (r_c_col == '0) begin
            w_kind = cdap_pkg::K_FIRST_COL;
        end else begin
            w_kind = cdap_pkg::K_GENERAL;
        end
    end

    assign w_out_load = (r_state == cdap_pkg::S_OUT) && (!r_out_valid || o_out.ready);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cdap_pkg::S_CLEAR: begin
                if (r_clr_addr == ADDR_LAST) n_state = cdap_pkg::S_IDLE;
            end
            cdap_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (w_clear_ev)  n_state = cdap_pkg::S_OUT;
                    else if (w_hit)  n_state = cdap_pkg::S_PLAN;
                    else             n_state = cdap_pkg::S_DIV;
                end
            end
            cdap_pkg::S_DIV: begin
                if (w_rem_rsp.done) n_state = cdap_pkg::S_PLAN;
            end
            cdap_pkg::S_PLAN: begin
                unique case (w_kind)
                    cdap_pkg::K_FIRST_COL: n_state = cdap_pkg::S_RD_C;
                    cdap_pkg::K_GENERAL:   n_state = cdap_pkg::S_RD_B;
                    default:               n_state = cdap_pkg::S_WR;
                endcase
            end
            cdap_pkg::S_RD_B: n_state = cdap_pkg::S_RD_C;
            cdap_pkg::S_RD_C: n_state = cdap_pkg::S_WR;
            cdap_pkg::S_WR:   n_state = cdap_pkg::S_OUT;
            cdap_pkg::S_OUT: begin
                if (w_out_load) begin
                    n_state = (r_kind == cdap_pkg::K_CLEAR) ? cdap_pkg::S_CLEAR
                                                            : cdap_pkg::S_IDLE;
                end
            end
            default: n_state = cdap_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        i_in.ready         = 1'b0;
        w_rem_req.start    = 1'b0;
        w_rem_req.dividend = i_in.mb_position;
        w_rem_req.divisor  = cdap_pkg::DVS_W'(w_eff);
        w_we               = 1'b0;
        w_waddr            = {w_col_m1, r_k};
        w_wdata            = r_x;
        w_raddr            = {w_col_m1, r_k};
        unique case (r_state)
            cdap_pkg::S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                w_wdata = '0;
            end
            cdap_pkg::S_IDLE: begin
                i_in.ready      = 1'b1;
                w_rem_req.start = i_in.valid && !w_clear_ev && !w_hit;
            end
            cdap_pkg::S_RD_C: begin
                w_raddr = (r_kind == cdap_pkg::K_FIRST_COL) ? {CW'(0), r_k}
                                                            : {r_c_col, r_k};
            end
            cdap_pkg::S_WR: begin
                // First row at column zero leaves the store alone.
                w_we = (r_kind != cdap_pkg::K_FIRST_ROW) || (r_c_col != '0);
                if (r_kind == cdap_pkg::K_FIRST_COL) w_waddr = {w_last_col, r_k};
            end
            default: begin
            end
        endcase
    end

    // Result selection.
    always_comb begin
        w_res_a = w_miss;
        w_res_b = w_miss;
        w_res_c = w_miss;
        unique case (r_kind)
            cdap_pkg::K_FIRST_ROW: begin
                if (r_c_col != '0) w_res_a = r_x;
            end
            cdap_pkg::K_FIRST_COL: begin
                w_res_c = r_c;
            end
            cdap_pkg::K_GENERAL: begin
                w_res_a = r_x;
                w_res_b = r_b;
                w_res_c = r_c;
            end
            default: begin
            end
        endcase
    end

    assign w_since_base = r_rs ? '0 : r_since;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbs <= cdap_pkg::MBS_RESET;
            r_pix <= cdap_pkg::PIX_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cdap_pkg::REG_MBS_PER_ROW: r_mbs <= i_cfg_data[cdap_pkg::MBS_W-1:0];
                cdap_pkg::REG_PIXEL_BITS:  r_pix <= i_cfg_data[cdap_pkg::PIX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cdap_pkg::S_CLEAR;
            r_clr_addr  <= '0;
            r_since     <= '0;
            r_c_ok      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == cdap_pkg::S_CLEAR) begin
                r_clr_addr <= (r_clr_addr == ADDR_LAST) ? '0 : r_clr_addr + 1'b1;
            end
            // Column count changed: drop the cached column.
            if (i_cfg_we && (i_cfg_idx == cdap_pkg::REG_MBS_PER_ROW)) begin
                r_c_ok <= 1'b0;
            end else if (w_rem_rsp.done) begin
                r_c_ok <= 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
                // Advance the count on the last coefficient, saturate at the column count.
                if ((r_k == cdap_pkg::COEF_IDX_W'(cdap_pkg::VEC_LEN - 1)) &&
                    (32'(w_since_base) < 32'(w_eff)) && (w_since_base != '1)) begin
                    r_since <= w_since_base + 1'b1;
                end else begin
                    r_since <= w_since_base;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pos <= i_in.mb_position;
            r_rs  <= i_in.resync;
            r_k   <= i_in.coef_index;
            r_x   <= i_in.left_coef;
            if (w_clear_ev) r_kind <= cdap_pkg::K_CLEAR;
        end
        if (r_state == cdap_pkg::S_PLAN) r_kind <= w_kind;
        if (w_rem_rsp.done) begin
            r_c_pos  <= r_pos;
            r_c_col  <= w_rem_rsp.remainder[CW-1:0];
            r_c_row0 <= 32'(r_pos) < 32'(w_eff);
        end
        if (r_state == cdap_pkg::S_RD_C) r_b <= r_rdata;
        if (r_state == cdap_pkg::S_WR)   r_c <= r_rdata;
        if (w_out_load) begin
            r_out_a <= w_res_a;
            r_out_b <= w_res_b;
            r_out_c <= w_res_c;
        end
    end

    // Line store: at most one write and one registered read each cycle.
    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= w_wdata;
        r_rdata <= mem[w_raddr];
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.pred_left       = r_out_a;
    assign o_out.pred_above_left = r_out_b;
    assign o_out.pred_above      = r_out_c;

`include "chroma_dc_ac_prediction_neighbors_assert.svh"

    `CDAP_ASSERT_NEXT(a_one_beat, i_clk, i_rst_n, w_accept, !i_in.ready, "accepted while busy")
    `CDAP_ASSERT_NOW(a_rem_wait, i_clk, i_rst_n, w_rem_rsp.done, r_state == cdap_pkg::S_DIV, "bad done")
    `CDAP_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, w_out_load, r_out_valid, "result not presented")

endmodule

/* verif/testbench.sv */
module testbench;

    // Column capacity of the line store under test; the DUT gets the same value.
    localparam int NB_COLS   = 64;
    localparam int NB_DEPTH  = NB_COLS * cdap_pkg::VEC_LEN;
    // Cycles for one full clearing pass of the line store, plus some slack.
    localparam int CLEAR_GAP = NB_DEPTH + 64;
    localparam int N_PHASES  = 8;

    typedef struct {
        logic [cdap_pkg::POS_W-1:0]         pos;
        logic                               rs;
        logic [cdap_pkg::COEF_IDX_W-1:0]    k;
        logic signed [cdap_pkg::COEF_W-1:0] x;
    } t_coef_beat;

    typedef struct packed {
        logic signed [cdap_pkg::COEF_W-1:0] left;
        logic signed [cdap_pkg::COEF_W-1:0] above_left;
        logic signed [cdap_pkg::COEF_W-1:0] above;
    } t_neighbors;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [cdap_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [cdap_pkg::CFG_DATA_W-1:0] i_cfg_data;

    cdap_in_if  coef_if ();
    cdap_out_if nb_if ();

    chroma_dc_ac_prediction_neighbors #(
        .MAX_COLS (NB_COLS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (coef_if),
        .o_out      (nb_if)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow of the block: line store, macroblock count, register copies
    // ------------------------------------------------------------------
    logic [cdap_pkg::COEF_W-1:0] nb_store [0:NB_DEPTH-1];
    int unsigned                 mb_count;
    logic [cdap_pkg::MBS_W-1:0]  cfg_cols;
    logic [cdap_pkg::PIX_W-1:0]  cfg_bits;

    t_coef_beat coef_queue[$];      // beats waiting to be sent
    t_neighbors neighbor_queue[$];  // neighbor sets still owed by the DUT

    int offered_cnt = 0;   // beats put on the bus by the driver
    int taken_cnt   = 0;   // beats the DUT has accepted
    int mismatch_cnt = 0;

    // Clamp the column register the same way the block does.
    function automatic int unsigned eff_cols();
        if (cfg_cols == '0) return 1;
        if (int'(cfg_cols) > NB_COLS) return NB_COLS;
        return int'(cfg_cols);
    endfunction

    task automatic wipe_store();
        for (int i = 0; i < NB_DEPTH; i++) nb_store[i] = '0;
    endtask

    // Work out the three neighbors for one accepted beat and update the shadow.
    task automatic predict_neighbors(input t_coef_beat b, output t_neighbors r);
        int unsigned cols, col, row;
        logic [cdap_pkg::COEF_W-1:0] dflt, miss;
        cols = eff_cols();
        col  = int'(b.pos) % cols;
        row  = int'(b.pos) / cols;
        // DC default wraps to 16 bits for the large pixel depths
        dflt = 16'(32'd1 << (int'(cfg_bits) + 2));
        miss = (b.k == '0) ? dflt : '0;

        if (b.rs) mb_count = 0;

        if (b.pos == '0 || b.rs) begin
            // picture start or resync: drop everything above
            wipe_store();
            r.left = miss;
            r.above_left = miss;
            r.above = miss;
        end else if (row == 0 || mb_count < cols) begin
            // nothing above yet, only a left neighbor past column zero
            r.left = (col == 0) ? miss : b.x;
            r.above_left = miss;
            r.above = miss;
            if (col > 0) nb_store[(col - 1) * cdap_pkg::VEC_LEN + b.k] = b.x;
        end else if (col == 0) begin
            // first column: the coefficient belongs to the end of the row above
            r.left = miss;
            r.above_left = miss;
            r.above = nb_store[b.k];
            nb_store[(cols - 1) * cdap_pkg::VEC_LEN + b.k] = b.x;
        end else begin
            r.left = b.x;
            r.above_left = nb_store[(col - 1) * cdap_pkg::VEC_LEN + b.k];
            r.above = nb_store[col * cdap_pkg::VEC_LEN + b.k];
            nb_store[(col - 1) * cdap_pkg::VEC_LEN + b.k] = b.x;
        end

        // count macroblocks on the last coefficient, saturate at the row width
        if (b.k == cdap_pkg::COEF_IDX_W'(cdap_pkg::VEC_LEN - 1) &&
            mb_count < cols && mb_count < 127) mb_count++;
    endtask

    task automatic note_failure(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("%s", msg);
    endtask

    // ------------------------------------------------------------------
    // Driver: present queued beats at the falling edge in random bursts
    // ------------------------------------------------------------------
    int tx_burst = 8;
    int tx_gap   = 0;

    always @(negedge i_clk) begin
        t_coef_beat b;
        if (!i_rst_n) begin
            coef_if.valid <= 1'b0;
        end else if (coef_if.valid && taken_cnt != offered_cnt) begin
            // hold the beat until the DUT takes it
        end else if (tx_gap > 0) begin
            tx_gap--;
            coef_if.valid <= 1'b0;
        end else if (coef_queue.size() > 0) begin
            b = coef_queue.pop_front();
            coef_if.mb_position <= b.pos;
            coef_if.resync      <= b.rs;
            coef_if.coef_index  <= b.k;
            coef_if.left_coef   <= b.x;
            coef_if.valid       <= 1'b1;
            offered_cnt++;
            tx_burst--;
            if (tx_burst <= 0) begin
                // pick the next gap and burst; some bursts run long with no idling
                tx_gap   = $urandom_range(1, 30);
                tx_burst = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                       : $urandom_range(1, 20);
            end
        end else begin
            coef_if.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: ready follows a randomly picked mode: always ready, random, or long stalls
    // ------------------------------------------------------------------
    int   rx_mode      = 0;
    int   rx_mode_left = 0;
    int   rx_hold      = 0;
    logic rx_level     = 1'b1;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            nb_if.ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 2);
                rx_mode_left = $urandom_range(50, 400);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                0: begin
                    nb_if.ready <= 1'b1;
                end
                1: begin
                    nb_if.ready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    // long stalls broken by short open windows
                    if (rx_hold == 0) begin
                        rx_level = ~rx_level;
                        rx_hold  = rx_level ? $urandom_range(1, 12) : $urandom_range(1, 40);
                    end else begin
                        rx_hold--;
                    end
                    nb_if.ready <= rx_level;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check results first, then predict for the beat taken now
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_neighbors want, got;
        t_coef_beat b;
        if (i_rst_n) begin
            if (nb_if.valid && nb_if.ready) begin
                got.left       = nb_if.pred_left;
                got.above_left = nb_if.pred_above_left;
                got.above      = nb_if.pred_above;
                if (neighbor_queue.size() == 0) begin
                    note_failure($sformatf("unexpected result: left %0d above_left %0d above %0d",
                                           got.left, got.above_left, got.above));
                end else begin
                    want = neighbor_queue.pop_front();
                    if (got.left !== want.left || got.above_left !== want.above_left ||
                        got.above !== want.above) begin
                        note_failure($sformatf(
                            "mismatch: left %0d/%0d above_left %0d/%0d above %0d/%0d (exp/got)",
                            want.left, got.left, want.above_left, got.above_left,
                            want.above, got.above));
                    end
                end
            end
            if (coef_if.valid && coef_if.ready) begin
                b.pos = coef_if.mb_position;
                b.rs  = coef_if.resync;
                b.k   = coef_if.coef_index;
                b.x   = coef_if.left_coef;
                predict_neighbors(b, want);
                neighbor_queue.push_back(want);
                taken_cnt++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_coef(input logic [cdap_pkg::POS_W-1:0] pos, input logic rs,
                             input logic [cdap_pkg::COEF_IDX_W-1:0] k,
                             input logic [cdap_pkg::COEF_W-1:0] x);
        t_coef_beat b;
        b.pos = pos;
        b.rs  = rs;
        b.k   = k;
        b.x   = x;
        coef_queue.push_back(b);
    endtask

    function automatic logic [cdap_pkg::COEF_W-1:0] pick_coef();
        case ($urandom_range(0, 15))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly raster walks of whole macroblocks after a picture start or
    // resync, with dropped coefficients, position jumps and loose noise beats.
    task automatic fill_phase(input int n_items);
        int unsigned cols;
        int made, n_mb;
        logic [cdap_pkg::POS_W-1:0] pos;
        logic rs;
        cols = eff_cols();
        made = 0;
        while (made < n_items) begin
            if ($urandom_range(0, 99) < 85) begin
                if ($urandom_range(0, 4) == 0) begin
                    pos = '0;
                    rs  = 1'($urandom_range(0, 1));
                end else begin
                    pos = 16'($urandom_range(1, 400));
                    rs  = 1'b1;
                end
                n_mb = $urandom_range(2, 3 * cols + 3);
                if (n_mb * cdap_pkg::VEC_LEN > n_items - made + cdap_pkg::VEC_LEN)
                    n_mb = (n_items - made) / cdap_pkg::VEC_LEN + 1;
                for (int m = 0; m < n_mb; m++) begin
                    for (int kk = 0; kk < cdap_pkg::VEC_LEN; kk++) begin
                        if (made < n_items && $urandom_range(0, 99) >= 3) begin
                            push_coef(pos, (m == 0 && kk == 0) ? rs : 1'b0,
                                      cdap_pkg::COEF_IDX_W'(kk), pick_coef());
                            made++;
                        end
                    end
                    pos = pos + (($urandom_range(0, 19) == 0) ? 16'($urandom_range(2, 5))
                                                              : 16'd1);
                end
            end else begin
                push_coef(16'($urandom), $urandom_range(0, 15) == 0,
                          cdap_pkg::COEF_IDX_W'($urandom), pick_coef());
                made++;
            end
        end
    endtask

    // Hold until every beat is sent and every result is back.
    task automatic drain_block();
        while (coef_queue.size() != 0 || taken_cnt != offered_cnt ||
               neighbor_queue.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [cdap_pkg::CFG_IDX_W-1:0] idx, input int val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= cdap_pkg::CFG_DATA_W'(val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == cdap_pkg::REG_MBS_PER_ROW) cfg_cols = cdap_pkg::MBS_W'(val);
        else cfg_bits = cdap_pkg::PIX_W'(val);
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------
    initial begin
        int phase_cols [N_PHASES];
        int phase_bits [N_PHASES];
        int phase_len  [N_PHASES];

        phase_cols = '{1, 3, 0, 5, 127, 64, 4, 2};
        phase_bits = '{12, 13, 15, 14, 7, 4, 0, 9};
        phase_len  = '{110, 110, 80, 100, 60, 60, 100, 110};

        coef_if.valid       = 1'b0;
        coef_if.mb_position = '0;
        coef_if.resync      = 1'b0;
        coef_if.coef_index  = '0;
        coef_if.left_coef   = '0;
        nb_if.ready         = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = '0;
        i_cfg_data          = '0;
        i_rst_n             = 1'b0;

        wipe_store();
        mb_count = 0;
        cfg_cols = cdap_pkg::MBS_RESET;
        cfg_bits = cdap_pkg::PIX_RESET;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // let the clearing pass after reset finish
        repeat (CLEAR_GAP) @(posedge i_clk);

        // Directed: two columns, four-bit pixels, walk every neighbor rule.
        write_reg(cdap_pkg::REG_MBS_PER_ROW, 2);
        write_reg(cdap_pkg::REG_PIXEL_BITS, 4);
        push_coef(16'd0, 1'b0, 4'd0, 16'd100);         // picture start
        push_coef(16'd0, 1'b0, 4'd15, 16'hFFFF);
        push_coef(16'd1, 1'b0, 4'd0, 16'h7FFF);        // first row, left only
        push_coef(16'd1, 1'b0, 4'd15, 16'h8000);
        push_coef(16'd2, 1'b0, 4'd0, 16'd7);           // first column
        push_coef(16'd2, 1'b0, 4'd15, 16'd3);          // count saturates
        push_coef(16'd3, 1'b0, 4'd0, 16'hFFFB);        // general case
        push_coef(16'd3, 1'b0, 4'd15, 16'h8000);
        push_coef(16'hFFFF, 1'b0, 4'd7, 16'h5555);     // top position
        push_coef(16'hFFFF, 1'b0, 4'd15, 16'hAAAA);
        push_coef(16'd4, 1'b1, 4'd0, 16'd9);           // resync mid-picture
        push_coef(16'd5, 1'b0, 4'd0, 16'd11);          // too few since resync
        push_coef(16'd5, 1'b0, 4'd15, 16'd12);
        push_coef(16'd6, 1'b0, 4'd15, 16'd13);         // column zero, still young
        push_coef(16'd7, 1'b0, 4'd0, 16'hFFFE);        // general again
        push_coef(16'd0, 1'b1, 4'd15, 16'd0);          // resync at picture start
        drain_block();

        for (int p = 0; p < N_PHASES; p++) begin
            // registers change only with the block idle and its clear done
            repeat (CLEAR_GAP) @(posedge i_clk);
            write_reg(cdap_pkg::REG_MBS_PER_ROW, phase_cols[p]);
            write_reg(cdap_pkg::REG_PIXEL_BITS, phase_bits[p]);
            fill_phase(phase_len[p] / 2);
            // pause the sender until every result has come back
            drain_block();
            fill_phase(phase_len[p] - phase_len[p] / 2);
            drain_block();
        end

        repeat (CLEAR_GAP) @(posedge i_clk);
        if (neighbor_queue.size() != 0)
            note_failure($sformatf("%0d results never arrived", neighbor_queue.size()));

        if (mismatch_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #50_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/cdap_pkg.sv
hdl/cdap_in_if.sv
hdl/cdap_out_if.sv
hdl/cdap_rem.sv
hdl/chroma_dc_ac_prediction_neighbors.sv
verif/testbench.sv
